@@ hdl/mawd_pkg.sv @@
// Shared constants and types of the moving-average wall detector.
`timescale 1ns / 1ps

package mawd_pkg;

    // Number of samples held in the averaging ring.
    localparam int DEPTH = 10;

    // Fixed field widths.
    localparam int SAMPLE_W = 12;
    localparam int THR_W    = 12;
    localparam int AVG_W    = 12;
    localparam int HELD_W   = 4;

    // Widths that follow from the ring depth.
    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W   = SAMPLE_W + COUNT_W;
    localparam int ITER_W  = $clog2(SUM_W + 1);

    // Stream and configuration port widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLR_THR = 1'd1;

    // Threshold reset values.
    localparam logic [THR_W-1:0] SET_THR_RESET = 12'd150;
    localparam logic [THR_W-1:0] CLR_THR_RESET = 12'd170;

    // Handshake between the sequencer and the serial divider.
    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    dividend;
        logic [COUNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SUM_W-1:0]    quotient;
    } div_rsp_t;

endpackage

@@ hdl/mawd_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mawd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

@@ hdl/mawd_divider.sv @@
// Restoring serial divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module mawd_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mawd_pkg::div_req_t   req,
    output mawd_pkg::div_rsp_t   rsp
);

    import mawd_pkg::*;

    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] dvs_reg, dvs_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;
    logic               fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            iter_next = ITER_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? COUNT_W'(trial - {1'b0, dvs_reg}) : COUNT_W'(trial);
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hdl/moving_average_wall_detector.sv @@
// Top level: sample ring, running sum, hysteresis flag and output register.
`timescale 1ns / 1ps

// Each accepted beat carries one distance sample in millimetres. The sample is
// written into a ring of the last DEPTH samples held in a small RAM, a running
// sum and fill count are kept, the wall flag is updated with hysteresis from
// the exact sum against threshold times count, and the floored mean is worked
// out by a serial divider. Each sample passes in order through the update, in
// which the ring read issued on the accepting edge returns, the compare, which
// also starts the divider, the one-bit-per-cycle division, the capture of the
// quotient and the load of the output register. The next sample is accepted
// on the cycle after the result is loaded; a result left waiting on the output
// delays the next sample only once the following result is ready to be loaded.
// Samples are processed one at a time; a new sample is accepted while the
// previous result still waits on the output. The user must write the threshold
// registers through the cfg port only while the block is idle; the block
// itself does not enforce this.

module moving_average_wall_detector (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream. tdata: sample_mm [11:0], zero padding above.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mawd_pkg::S_TDATA_W-1:0]         s_tdata,
    // Result stream. tdata: average_mm [11:0], wall_present [12],
    // samples_held [16:13], zero padding above.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mawd_pkg::M_TDATA_W-1:0]         m_tdata,
    // Configuration write port.
    input  logic                                   cfg_wr_en,
    input  logic [mawd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mawd_pkg::CFG_DAT_W-1:0]         cfg_wr_data
);

    import mawd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_COMPARE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t             state_reg, state_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               wall_reg, wall_next;
    logic [THR_W-1:0]   set_thr_reg, set_thr_next;
    logic [THR_W-1:0]   clr_thr_reg, clr_thr_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic               m_valid_reg, m_valid_next;
    logic [AVG_W-1:0]   m_avg_reg, m_avg_next;
    logic               m_wall_reg, m_wall_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    logic               s_accept;
    logic               m_accept;
    logic               ring_full;
    logic               ram_wr_en;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic [SUM_W-1:0]   set_prod;
    logic [SUM_W-1:0]   clr_prod;
    logic               wall_cleared;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_valid_reg && m_tready;
    assign ring_full = (count_reg == COUNT_W'(DEPTH));

    // Sample ring. The read of the current slot is issued on the accepting
    // edge; the write back of that slot happens in the update cycle, so the
    // two never overlap on one entry.
    assign ram_wr_en = (state_reg == ST_UPDATE);

    mawd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    // Serial divider for the floored mean.
    assign div_req.start    = (state_reg == ST_COMPARE);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = count_reg;

    mawd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Threshold times count for the exact hysteresis tests, at full sum width.
    assign set_prod     = SUM_W'(set_thr_reg) * SUM_W'(count_reg);
    assign clr_prod     = SUM_W'(clr_thr_reg) * SUM_W'(count_reg);
    assign wall_cleared = wall_reg && (sum_reg > clr_prod) ? 1'b0 : wall_reg;

    // Next-state logic of the sequencer, the datapath and the output register.
    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        wall_next    = wall_reg;
        set_thr_next = set_thr_reg;
        clr_thr_next = clr_thr_reg;
        avg_next     = avg_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_avg_next   = m_avg_reg;
        m_wall_next  = m_wall_reg;
        m_count_next = m_count_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SET_THR: set_thr_next = cfg_wr_data;
                REG_CLR_THR: clr_thr_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Drop the overwritten sample once full, then add the new one.
                if (ring_full) begin
                    sum_next = sum_reg - SUM_W'(ram_rd_data) + SUM_W'(sample_reg);
                end else begin
                    sum_next   = sum_reg + SUM_W'(sample_reg);
                    count_next = count_reg + 1'b1;
                end
                slot_next  = (slot_reg == SLOT_W'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                // Clear test first, then set test on the possibly cleared flag.
                wall_next  = (!wall_cleared && (sum_reg < set_prod)) ? 1'b1 : wall_cleared;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    avg_next   = div_rsp.quotient[AVG_W-1:0];
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = avg_reg;
                    m_wall_next  = wall_reg;
                    m_count_next = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            wall_reg    <= 1'b0;
            set_thr_reg <= SET_THR_RESET;
            clr_thr_reg <= CLR_THR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            wall_reg    <= wall_next;
            set_thr_reg <= set_thr_next;
            clr_thr_reg <= clr_thr_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg  <= sample_next;
        avg_reg     <= avg_next;
        m_avg_reg   <= m_avg_next;
        m_wall_reg  <= m_wall_next;
        m_count_reg <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - AVG_W - 1 - HELD_W){1'b0}},
                       HELD_W'(m_count_reg), m_wall_reg, m_avg_reg};

    // The fill count never passes the ring depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("fill count above ring depth");

    // The write slot always points inside the ring.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(DEPTH - 1))
        else $error("write slot outside ring");

    // A presented result always covers at least one sample.
    a_held_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_count_reg != '0))
        else $error("result with empty window");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // An accepted sample is followed by the ring update cycle.
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_UPDATE))
        else $error("accepted sample not followed by update");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the moving-average wall detector.
`timescale 1ns / 1ps

module tb;
    import mawd_pkg::*;

    // One result beat split into its fields.
    typedef struct packed {
        logic [AVG_W-1:0]  average_mm;
        logic              wall_present;
        logic [HELD_W-1:0] samples_held;
    } wall_result_t;

    // How the receiver decides when it is ready.
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;
    // How a random phase places its two thresholds.
    typedef enum int {THR_NORMAL, THR_EQUAL, THR_CROSSED, THR_EXTREME} thr_mode_t;
    // How a run of random samples is shaped.
    typedef enum int {STIM_PLATEAU, STIM_NEAR, STIM_ANY, STIM_EDGE} stim_mode_t;

    localparam int IDLE_CYCLES    = 30;    // idle stretch after the last result arrives
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // sample_mm [11:0], zero padding above
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // average_mm [11:0], wall_present [12],
                                              // samples_held [16:13], padding above
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_SET_THR;
    logic [CFG_DAT_W-1:0] cfg_wr_data = '0;

    // Predicted state of the detector.
    int unsigned sample_store [DEPTH];
    int unsigned next_slot    = 0;
    int unsigned held_count   = 0;
    int unsigned window_sum   = 0;
    logic        wall_seen    = 1'b0;
    int unsigned set_thr      = SET_THR_RESET;
    int unsigned clr_thr      = CLR_THR_RESET;

    wall_result_t expected_results [$];
    int           mismatch_count = 0;
    int           hold_req_cnt   = 0;
    bit           sender_gaps    = 1'b1;
    int           burst_left     = 0;

    moving_average_wall_detector DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock with a 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Advances the window by one sample and works out the result it causes.
    function automatic wall_result_t predict_average(input logic [SAMPLE_W-1:0] sample);
        wall_result_t r;
        if (held_count >= DEPTH) begin
            window_sum -= sample_store[next_slot];
        end else begin
            held_count++;
        end
        sample_store[next_slot] = sample;
        window_sum += sample;
        next_slot = (next_slot + 1 >= DEPTH) ? 0 : next_slot + 1;

        // Clear test first, then the set test, both on the exact sum.
        if (wall_seen && window_sum > clr_thr * held_count) begin
            wall_seen = 1'b0;
        end
        if (!wall_seen && window_sum < set_thr * held_count) begin
            wall_seen = 1'b1;
        end

        r.average_mm   = AVG_W'(window_sum / held_count);
        r.wall_present = wall_seen;
        r.samples_held = HELD_W'(held_count);
        return r;
    endfunction

    // Draws one sample according to the shape of the current run.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input stim_mode_t mode,
                                                        input int centre, input int spread);
        int v;
        case (mode)
            STIM_ANY: begin
                v = $urandom_range(0, 4095);
            end
            STIM_EDGE: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 4094;
                    default: v = 4095;
                endcase
            end
            default: begin
                v = centre - spread + int'($urandom_range(0, 2 * spread));
            end
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_W'(v);
    endfunction

    // Monitor: checks every result beat, predicts every input beat and
    // follows register writes.
    always @(posedge aclk) begin
        wall_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, tdata %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[11:0] !== want.average_mm) begin
                        $display("%0t: average_mm expected %0d, actual %0d",
                                 $time, want.average_mm, m_tdata[11:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[12] !== want.wall_present) begin
                        $display("%0t: wall_present expected %0d, actual %0d",
                                 $time, want.wall_present, m_tdata[12]);
                        mismatch_count++;
                    end
                    if (m_tdata[16:13] !== want.samples_held) begin
                        $display("%0t: samples_held expected %0d, actual %0d",
                                 $time, want.samples_held, m_tdata[16:13]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_average(s_tdata[SAMPLE_W-1:0]));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SET_THR: set_thr = cfg_wr_data;
                    REG_CLR_THR: clr_thr = cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // Receiver: stalls on changing patterns, or holds off for a long stretch
    // whenever a test asks for it.
    initial begin
        int       hold_seen;
        int       hold_left;
        int       mode_left;
        int       period;
        int       duty;
        int       cyc;
        rx_mode_t mode;
        hold_seen = 0;
        hold_left = 0;
        mode_left = 0;
        period    = 2;
        duty      = 1;
        cyc       = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge aclk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
                period    = $urandom_range(2, 9);
                duty      = $urandom_range(1, period - 1);
            end
            mode_left--;
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ((cyc % period) < duty);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offers one sample and returns once it has been accepted. Between bursts
    // the sender leaves a random gap; tvalid stays high within a burst.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        int gap;
        if (burst_left == 0) begin
            gap = sender_gaps ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tdata  <= S_TDATA_W'(sample);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Stops sending and waits until every expected result has arrived. The
    // first edge lets the monitor record the last accepted beat.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both thresholds, one register per cycle; only called when idle.
    task automatic set_thresholds(input logic [THR_W-1:0] set_v, input logic [THR_W-1:0] clr_v);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SET_THR;
        cfg_wr_data <= set_v;
        @(posedge aclk);
        cfg_index   <= REG_CLR_THR;
        cfg_wr_data <= clr_v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // With the reset thresholds: extreme samples, the window growing to full,
    // older samples being overwritten, and the wall flag setting and clearing.
    task automatic test_fill_and_overwrite();
        logic [SAMPLE_W-1:0] seq [14] = '{12'hFFF, 12'h000, 12'hAAA, 12'h555,
                                          12'h000, 12'h000, 12'h000, 12'h000,
                                          12'h000, 12'h000, 12'h000, 12'h000,
                                          12'h000, 12'hFFF};
        foreach (seq[i]) send_sample(seq[i]);
        wait_for_results();
    endtask

    // Threshold extremes: a band that can neither set nor clear the flag,
    // then crossed thresholds where the clear and set tests both fire.
    task automatic test_threshold_extremes();
        set_thresholds(12'd0, 12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        wait_for_results();
        set_thresholds(12'd4095, 12'd0);
        send_sample(12'd0);
        send_sample(12'd4095);
        wait_for_results();
    endtask

    // Long receiver hold-off while samples keep coming, so the input stalls;
    // the sender then pauses until everything has drained.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (40) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    // Random phases: each picks thresholds, then sends runs of samples that
    // mostly sit on or near a threshold so the flag keeps toggling.
    task automatic test_random_phases(input int phases, input int per_phase);
        int         set_v;
        int         clr_v;
        int         centre;
        int         spread;
        int         run_left;
        int         pick;
        thr_mode_t  tm;
        stim_mode_t sm;
        centre = 0;
        spread = 0;
        sm     = STIM_ANY;
        for (int p = 0; p < phases; p++) begin
            tm = thr_mode_t'($urandom_range(0, 3));
            case (tm)
                THR_NORMAL: begin
                    set_v = $urandom_range(0, 3600);
                    clr_v = set_v + $urandom_range(0, 400);
                end
                THR_EQUAL: begin
                    set_v = $urandom_range(0, 4095);
                    clr_v = set_v;
                end
                THR_CROSSED: begin
                    clr_v = $urandom_range(0, 3000);
                    set_v = clr_v + $urandom_range(1, 1000);
                end
                default: begin
                    set_v = $urandom_range(0, 1) ? 4095 : 0;
                    clr_v = $urandom_range(0, 1) ? 4095 : 0;
                end
            endcase
            set_thresholds(THR_W'(set_v), THR_W'(clr_v));
            sender_gaps = (p % 3 != 2);
            if (p == 5) begin
                hold_req_cnt <= hold_req_cnt + 1;
            end
            run_left = 0;
            for (int n = 0; n < per_phase; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(4, 30);
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        sm = STIM_PLATEAU;
                    end else if (pick < 8) begin
                        sm = STIM_NEAR;
                    end else if (pick == 8) begin
                        sm = STIM_ANY;
                    end else begin
                        sm = STIM_EDGE;
                    end
                    case ($urandom_range(0, 2))
                        0: centre = set_v;
                        1: centre = clr_v;
                        default: centre = $urandom_range(0, 4095);
                    endcase
                    if (sm == STIM_PLATEAU) begin
                        spread = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
                    end else begin
                        spread = 200;
                    end
                end
                send_sample(pick_sample(sm, centre, spread));
                run_left--;
            end
            wait_for_results();
        end
        sender_gaps = 1'b1;
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_and_overwrite();
        test_threshold_extremes();
        test_backpressure();
        test_random_phases(14, 130);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mawd_pkg.sv
hdl/mawd_ram.sv
hdl/mawd_divider.sv
hdl/moving_average_wall_detector.sv
verif/tb.sv
